// ===== rtl/core/aavr_pkg.sv =====
// Package with payload types and constants for the axis-angle vector rotate unit.
package aavr_pkg;

   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic        [15:0] turn_angle;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

   function automatic logic signed [33:0] atan_turn(input int idx);
      logic signed [33:0] r;
      case (idx)
         0: r = 34'sd536870912;   1: r = 34'sd316933406;   2: r = 34'sd167458907;
         3: r = 34'sd85004756;    4: r = 34'sd42667331;    5: r = 34'sd21354465;
         6: r = 34'sd10679838;    7: r = 34'sd5340245;     8: r = 34'sd2670163;
         9: r = 34'sd1335087;     10: r = 34'sd667544;     11: r = 34'sd333772;
         12: r = 34'sd166886;     13: r = 34'sd83443;      14: r = 34'sd41722;
         15: r = 34'sd20861;      16: r = 34'sd10430;      17: r = 34'sd5215;
         18: r = 34'sd2608;       19: r = 34'sd1304;       20: r = 34'sd652;
         21: r = 34'sd326;        22: r = 34'sd163;        23: r = 34'sd81;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/axis_angle_vector_rotate_unit.sv =====
// Top level of the axis-angle vector rotate unit: a pipelined Rodrigues rotation.
//
// Usage: present an item on req_valid/req_data (axis Q2.14, angle as a
// fraction of a turn, vector Q16.16). The rotated vector leaves on
// rsp_valid/rsp_data, saturated to 32 bits, one result per item, in order.
// The pipeline has CORDIC_STAGES + 6 register stages: one for phase setup,
// one per CORDIC iteration, one for quadrant mapping, one each for the
// axis products, the matrix entries, the nine row products and the row sums
// with saturation. One item may enter every cycle while req_ready is high.
// The sequence of CORDIC iterations sets the depth, and the 32x35 products
// with their sums and rounding in the matrix stage set the widest path
// between registers.
// Reset clears every valid bit; payload registers keep their contents.
// When rsp_ready is low, the output register and the full stages behind it
// hold; req_ready stays high while any stage, including the output register,
// is empty, so bubbles are squeezed out during a stall.
module axis_angle_vector_rotate_unit
   import aavr_pkg::*;
#(
   parameter int CORDIC_STAGES = 16,
   parameter int ANGLE_BITS    = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NS = CORDIC_STAGES + 6;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
   } side_type;

   // Stage valid bits and per-stage enables.
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // Stage 0: phase setup.
   logic signed [33:0] cx_ff [CORDIC_STAGES+1];
   logic signed [33:0] cy_ff [CORDIC_STAGES+1];
   logic signed [33:0] cz_ff [CORDIC_STAGES+1];
   logic        [1:0]  quad_ff [CORDIC_STAGES+1];
   side_type           sd_ff [CORDIC_STAGES+1];

   logic [31:0] phase;
   always_comb begin
      logic [ANGLE_BITS-1:0] ang;
      ang = '0;
      for (int b = 0; b < ANGLE_BITS; b++) begin
         if (b < 16) ang[b] = req_data.turn_angle[b];
      end
      phase = 32'(ang) << (32 - ANGLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         cx_ff[0]   <= GAIN_Q30;
         cy_ff[0]   <= '0;
         cz_ff[0]   <= $signed({4'b0000, phase[29:0]});
         quad_ff[0] <= phase[31:30];
         sd_ff[0]   <= '{req_data.axis_x, req_data.axis_y, req_data.axis_z,
                         req_data.vec_x, req_data.vec_y, req_data.vec_z};
      end
   end

   // CORDIC iterations, one per stage.
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (en[g+1]) begin
            if (!cz_ff[g][33]) begin
               cx_ff[g+1] <= cx_ff[g] - (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] + (cx_ff[g] >>> g);
               cz_ff[g+1] <= cz_ff[g] - atan_turn(g);
            end else begin
               cx_ff[g+1] <= cx_ff[g] + (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] - (cx_ff[g] >>> g);
               cz_ff[g+1] <= cz_ff[g] + atan_turn(g);
            end
            quad_ff[g+1] <= quad_ff[g];
            sd_ff[g+1]   <= sd_ff[g];
         end
      end
   end

   localparam int SQ = CORDIC_STAGES + 1;

   // Quadrant mapping.
   logic signed [33:0] c_ff, s_ff;
   side_type           sq_ff;
   always_ff @(posedge clock) begin
      if (en[SQ]) begin
         case (quad_ff[CORDIC_STAGES])
            2'd1: begin c_ff <= -cy_ff[CORDIC_STAGES]; s_ff <= cx_ff[CORDIC_STAGES]; end
            2'd2: begin c_ff <= -cx_ff[CORDIC_STAGES]; s_ff <= -cy_ff[CORDIC_STAGES]; end
            2'd3: begin c_ff <= cy_ff[CORDIC_STAGES]; s_ff <= -cx_ff[CORDIC_STAGES]; end
            default: begin c_ff <= cx_ff[CORDIC_STAGES]; s_ff <= cy_ff[CORDIC_STAGES]; end
         endcase
         sq_ff <= sd_ff[CORDIC_STAGES];
      end
   end

   // Axis products: a_i*a_j, a_k*s, c and 1 - c.
   logic signed [31:0] aa_ff [6];
   logic signed [49:0] as_ff [3];
   logic signed [34:0] omc_ff;
   logic signed [33:0] c2_ff;
   side_type           sa_ff;
   always_ff @(posedge clock) begin
      if (en[SQ+1]) begin
         aa_ff[0] <= sq_ff.ax * sq_ff.ax;
         aa_ff[1] <= sq_ff.ax * sq_ff.ay;
         aa_ff[2] <= sq_ff.ax * sq_ff.az;
         aa_ff[3] <= sq_ff.ay * sq_ff.ay;
         aa_ff[4] <= sq_ff.ay * sq_ff.az;
         aa_ff[5] <= sq_ff.az * sq_ff.az;
         as_ff[0] <= 50'(sq_ff.ax) * 50'(s_ff);
         as_ff[1] <= 50'(sq_ff.ay) * 50'(s_ff);
         as_ff[2] <= 50'(sq_ff.az) * 50'(s_ff);
         omc_ff   <= 35'(ONE_Q30) - 35'(c_ff);
         c2_ff    <= c_ff;
         sa_ff    <= sq_ff;
      end
   end

   // Matrix entries, Q.58 rounded to Q.26.
   logic signed [32:0] m_ff [9];
   side_type           sm_ff;

   function automatic logic signed [32:0] rnd32(input logic signed [67:0] v);
      logic signed [67:0] t;
      t = v + 68'sd2147483648;
      return 33'(t >>> 32);
   endfunction

   always_ff @(posedge clock) begin
      logic signed [67:0] p [6];
      logic signed [67:0] cq;
      logic signed [67:0] s [3];
      if (en[SQ+2]) begin
         for (int k = 0; k < 6; k++) begin
            p[k] = 68'(aa_ff[k]) * 68'(omc_ff);
         end
         cq = 68'(c2_ff) <<< 28;
         for (int k = 0; k < 3; k++) begin
            s[k] = 68'(as_ff[k]) <<< 14;
         end
         m_ff[0] <= rnd32(p[0] + cq);
         m_ff[1] <= rnd32(p[1] - s[2]);
         m_ff[2] <= rnd32(p[2] + s[1]);
         m_ff[3] <= rnd32(p[1] + s[2]);
         m_ff[4] <= rnd32(p[3] + cq);
         m_ff[5] <= rnd32(p[4] - s[0]);
         m_ff[6] <= rnd32(p[2] - s[1]);
         m_ff[7] <= rnd32(p[4] + s[0]);
         m_ff[8] <= rnd32(p[5] + cq);
         sm_ff   <= sa_ff;
      end
   end

   // Nine row products.
   logic signed [64:0] pr_ff [9];
   always_ff @(posedge clock) begin
      if (en[SQ+3]) begin
         for (int r = 0; r < 3; r++) begin
            pr_ff[3*r]   <= 65'(m_ff[3*r])   * 65'(sm_ff.vx);
            pr_ff[3*r+1] <= 65'(m_ff[3*r+1]) * 65'(sm_ff.vy);
            pr_ff[3*r+2] <= 65'(m_ff[3*r+2]) * 65'(sm_ff.vz);
         end
      end
   end

   // Row sums, rounding and saturation.
   function automatic logic signed [31:0] sat_row(input logic signed [66:0] acc);
      logic signed [66:0] t;
      t = (acc + 67'sd33554432) >>> 26;
      if (t > 67'sd2147483647) return 32'sh7fffffff;
      if (t < -67'sd2147483648) return 32'sh80000000;
      return t[31:0];
   endfunction

   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (en[SQ+4]) begin
         out_ff.out_x <= sat_row(67'(pr_ff[0]) + 67'(pr_ff[1]) + 67'(pr_ff[2]));
         out_ff.out_y <= sat_row(67'(pr_ff[3]) + 67'(pr_ff[4]) + 67'(pr_ff[5]));
         out_ff.out_z <= sat_row(67'(pr_ff[6]) + 67'(pr_ff[7]) + 67'(pr_ff[8]));
      end
   end

   assign rsp_valid = vld_ff[NS-1];
   assign rsp_data  = out_ff;

`ifndef SYNTH
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result item changed during a stall.");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Input not ready with an empty output stage.");
   a_no_new: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[NS-2] && rsp_ready |=> !rsp_valid)
      else $error("Result item appeared without a source.");
`endif

endmodule
